// ----- design/dfmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dfmt_pkg;

  // Format limits.
  localparam int MAX_FRAC_DIGITS = 8;
  localparam int FRAC_BITS       = 16;

  // Integer part is at most five decimal digits (65535).
  localparam int INT_DIGITS      = 5;

  // Four digit stages share the fraction digits between them.
  localparam int DIGIT_STAGES    = 4;
  localparam int FRAC_PER_STAGE  = (MAX_FRAC_DIGITS + DIGIT_STAGES - 1) / DIGIT_STAGES;
  localparam int NDIG_W          = $clog2(MAX_FRAC_DIGITS + 1);

  // Character slots in print order: minus, integer digits, dot, fraction digits.
  localparam int SLOT_MINUS = 0;
  localparam int SLOT_INT0  = 1;
  localparam int SLOT_DOT   = SLOT_INT0 + INT_DIGITS;
  localparam int SLOT_FRAC0 = SLOT_DOT + 1;
  localparam int NUM_SLOTS  = SLOT_FRAC0 + MAX_FRAC_DIGITS;

  // ASCII codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Command codes.
  localparam logic CMD_UINT  = 1'b0;
  localparam logic CMD_FIXED = 1'b1;

  typedef logic [3:0] digit_t;
  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // One item as it travels down the digit pipeline.
  typedef struct packed {
    logic                                cmd;
    logic                                neg;
    logic [NDIG_W-1:0]                   ndig;
    logic [15:0]                         rem;
    digit_t [INT_DIGITS-1:0]             idig;
    logic [FRAC_BITS-1:0]                frac;
    digit_t [MAX_FRAC_DIGITS-1:0]        fdig;
  } item_t;

  // Peels one decimal digit of weight base off the integer remainder.
  // The digit is found by parallel compares against the multiples of base.
  function automatic item_t peel_digit(item_t it, int pos, int base);
    item_t  r;
    digit_t d;
    r = it;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (int'(it.rem) >= k * base) begin
        d = 4'(k);
      end
    end
    r.idig[pos] = d;
    r.rem       = it.rem - 16'(int'(d) * base);
    return r;
  endfunction

  // Produces this stage's share of fraction digits; each digit is the
  // integer part of the fraction times ten.
  function automatic item_t frac_group(item_t it, int grp);
    item_t                r;
    logic [FRAC_BITS+3:0] t;
    int                   idx;
    r = it;
    for (int m = 0; m < FRAC_PER_STAGE; m++) begin
      idx = grp * FRAC_PER_STAGE + m;
      if (idx < MAX_FRAC_DIGITS) begin
        t = {3'b000, r.frac, 1'b0} + {1'b0, r.frac, 3'b000};
        r.fdig[idx] = t[FRAC_BITS+3:FRAC_BITS];
        r.frac      = t[FRAC_BITS-1:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/dfmt_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dfmt_emit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  item_valid,
  input  wire dfmt_pkg::item_t item,
  output logic                 item_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [7:0]           out_char_code,
  output logic                 out_last
);

  // Remaining characters of the item being printed, one bit per slot.
  dfmt_pkg::slot_mask_t mask_r, mask_nxt;
  logic [7:0]           chars_r [dfmt_pkg::NUM_SLOTS];
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           char_r;
  logic                 last_r;

  dfmt_pkg::slot_mask_t load_mask;
  logic [7:0]           load_chars [dfmt_pkg::NUM_SLOTS];
  dfmt_pkg::slot_mask_t pick;
  logic [7:0]           pick_char;
  logic                 send;
  logic                 is_last;
  logic                 load;

  // Build the slot mask and characters of an arriving item.
  always_comb begin
    logic started;
    started = 1'b0;
    load_mask = '0;
    for (int i = 0; i < dfmt_pkg::NUM_SLOTS; i++) begin
      load_chars[i] = dfmt_pkg::CH_ZERO;
    end
    load_mask[dfmt_pkg::SLOT_MINUS]  = (item.cmd == dfmt_pkg::CMD_FIXED) && item.neg;
    load_chars[dfmt_pkg::SLOT_MINUS] = dfmt_pkg::CH_MINUS;
    // Leading zeros are dropped; the units digit always prints.
    for (int i = 0; i < dfmt_pkg::INT_DIGITS; i++) begin
      if (item.idig[i] != '0) begin
        started = 1'b1;
      end
      load_mask[dfmt_pkg::SLOT_INT0 + i]  = started || (i == dfmt_pkg::INT_DIGITS - 1);
      load_chars[dfmt_pkg::SLOT_INT0 + i] = dfmt_pkg::CH_ZERO + {4'b0000, item.idig[i]};
    end
    load_mask[dfmt_pkg::SLOT_DOT]  = (item.cmd == dfmt_pkg::CMD_FIXED);
    load_chars[dfmt_pkg::SLOT_DOT] = dfmt_pkg::CH_DOT;
    for (int j = 0; j < dfmt_pkg::MAX_FRAC_DIGITS; j++) begin
      load_mask[dfmt_pkg::SLOT_FRAC0 + j] = (item.cmd == dfmt_pkg::CMD_FIXED) &&
                                            (j < int'(item.ndig));
      load_chars[dfmt_pkg::SLOT_FRAC0 + j] = dfmt_pkg::CH_ZERO + {4'b0000, item.fdig[j]};
    end
  end

  // Pick the earliest remaining slot and emit it when the output register frees.
  always_comb begin
    pick      = mask_r & (~mask_r + 1'b1);
    is_last   = (mask_r & (mask_r - 1'b1)) == '0;
    send      = (mask_r != '0) && (!out_valid_r || out_ready);
    pick_char = '0;
    for (int i = 0; i < dfmt_pkg::NUM_SLOTS; i++) begin
      if (pick[i]) begin
        pick_char = pick_char | chars_r[i];
      end
    end
    item_ready = (mask_r == '0) || (send && is_last);
    load       = item_valid && item_ready;
    if (load) begin
      mask_nxt = load_mask;
    end else if (send) begin
      mask_nxt = mask_r & ~pick;
    end else begin
      mask_nxt = mask_r;
    end
    if (send) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Character storage and output register.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < dfmt_pkg::NUM_SLOTS; i++) begin
        chars_r[i] <= load_chars[i];
      end
    end
    if (send) begin
      char_r <= pick_char;
      last_r <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

// ----- design/decimal_number_formatter.sv -----
// The first character of an item passes through the input stage, four digit stages, the
// sequencer's character store and the single character output register, which sends one
// character per cycle while out_ready is high. An item has 1 to 15 characters.
// A five-stage digit pipeline takes a new item every cycle while any stage is empty or the sequencer takes an item.
// Reset (rst_n low, synchronous) clears all valid bits and the pending character mask.
`timescale 1ns / 1ps
`default_nettype none

module decimal_number_formatter (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               in_cmd,
  input  wire signed [31:0] in_value,
  input  wire        [3:0]  in_frac_digits,
  output logic              out_valid,
  input  wire               out_ready,
  output logic       [7:0]  out_char_code,
  output logic              out_last
);

  localparam int NSTAGE = dfmt_pkg::DIGIT_STAGES + 1;

  dfmt_pkg::item_t    st_r   [NSTAGE];
  dfmt_pkg::item_t    st_nxt [NSTAGE];
  logic [NSTAGE-1:0]  vld_r, vld_nxt;
  logic [NSTAGE-1:0]  adv;
  logic               emit_ready;

  // Input stage: for fixed point, magnitude, saturated integer part, fraction, clamped count; else the low 16 bits.
  always_comb begin
    logic [31:0] mag;
    logic [31:0] ipart;
    mag   = in_value[31] ? (~in_value + 32'd1) : in_value;
    ipart = mag >> dfmt_pkg::FRAC_BITS;
    st_nxt[0] = '0;
    st_nxt[0].cmd = in_cmd;
    if (in_cmd == dfmt_pkg::CMD_FIXED) begin
      st_nxt[0].neg  = in_value[31];
      st_nxt[0].rem  = (ipart > 32'h0000_FFFF) ? 16'hFFFF : ipart[15:0];
      st_nxt[0].frac = mag[dfmt_pkg::FRAC_BITS-1:0];
      st_nxt[0].ndig = (int'(in_frac_digits) > dfmt_pkg::MAX_FRAC_DIGITS) ?
                       dfmt_pkg::NDIG_W'(dfmt_pkg::MAX_FRAC_DIGITS) :
                       dfmt_pkg::NDIG_W'(in_frac_digits);
    end else begin
      st_nxt[0].rem  = in_value[15:0];
    end
  end

  // Digit stages: one integer digit and a group of fraction digits each; the last also takes the units digit.
  always_comb begin
    dfmt_pkg::item_t t;
    st_nxt[1] = dfmt_pkg::frac_group(dfmt_pkg::peel_digit(st_r[0], 0, 10000), 0);
    st_nxt[2] = dfmt_pkg::frac_group(dfmt_pkg::peel_digit(st_r[1], 1, 1000), 1);
    st_nxt[3] = dfmt_pkg::frac_group(dfmt_pkg::peel_digit(st_r[2], 2, 100), 2);
    t = dfmt_pkg::peel_digit(st_r[3], 3, 10);
    // What is left after the tens is the units digit.
    t.idig[dfmt_pkg::INT_DIGITS-1] = t.rem[3:0];
    st_nxt[4] = dfmt_pkg::frac_group(t, 3);
  end

  // Stall logic: a stage moves when it is empty or its successor moves.
  always_comb begin
    adv[NSTAGE-1] = !vld_r[NSTAGE-1] || emit_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  assign in_ready = adv[0];

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTAGE; k++) begin
      if (adv[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Character sequencer with output register.
  dfmt_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (vld_r[NSTAGE-1]),
    .item          (st_r[NSTAGE-1]),
    .item_ready    (emit_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

`ifndef ASSERT_OFF
  // An accepted item always lands in the first stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted item did not enter the pipeline");

  // A finished item held back by the sequencer keeps its contents.
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTAGE-1] && !emit_ready |=> vld_r[NSTAGE-1] && $stable(st_r[NSTAGE-1]))
    else $error("stalled item in the last stage changed");

  // Only digits, the minus sign and the dot are ever printed.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code >= dfmt_pkg::CH_ZERO &&
                    out_char_code <= dfmt_pkg::CH_ZERO + 8'd9) ||
                   out_char_code == dfmt_pkg::CH_MINUS ||
                   out_char_code == dfmt_pkg::CH_DOT))
    else $error("character outside the printable set");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  // One number to be formatted, as offered on the input channel.
  typedef struct {
    logic        cmd;
    logic [31:0] value;
    logic [3:0]  ndig;
  } fmt_item_t;

  // One printed character as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } fmt_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  wire         in_ready;
  logic        in_cmd = dfmt_pkg::CMD_UINT;
  logic [31:0] in_value = '0;
  logic [3:0]  in_frac_digits = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [7:0]  out_char_code;
  wire         out_last;

  fmt_item_t pending_items[$];
  fmt_char_t expected_chars[$];

  int cyc = 0;
  int err_count = 0;
  int items_taken = 0;
  int fixed_taken = 0;
  int chars_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  decimal_number_formatter u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .in_frac_digits (in_frac_digits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_code  (out_char_code),
    .out_last       (out_last)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Random idling, switched off inside one calm window of the run.
  function automatic bit take_break();
    if (cyc >= 1200 && cyc < 1800) begin
      return 1'b0;
    end
    return $urandom_range(99) < 36;
  endfunction

  function automatic void append_char(input logic [7:0] code);
    fmt_char_t c;
    c.code = code;
    c.last = 1'b0;
    expected_chars.push_back(c);
  endfunction

  // Decimal print of a 16-bit number with leading zeros dropped.
  function automatic void append_decimal(input logic [15:0] num);
    int unsigned divs[4];
    int unsigned rest;
    int unsigned d;
    bit started;
    divs[0] = 10000;
    divs[1] = 1000;
    divs[2] = 100;
    divs[3] = 10;
    rest = num;
    started = 1'b0;
    for (int i = 0; i < 4; i++) begin
      d = rest / divs[i];
      if (d != 0) begin
        started = 1'b1;
      end
      if (started) begin
        append_char(dfmt_pkg::CH_ZERO + 8'(d));
        rest = rest % divs[i];
      end
    end
    append_char(dfmt_pkg::CH_ZERO + 8'(rest % 10));
  endfunction

  // Works out every character that one accepted item must produce.
  function automatic void predict_chars(input fmt_item_t it);
    logic [31:0] mag;
    logic [31:0] ipart;
    logic [63:0] mask;
    logic [63:0] frac;
    logic [63:0] t;
    int unsigned count;
    mask = (64'd1 << dfmt_pkg::FRAC_BITS) - 64'd1;
    if (it.cmd == dfmt_pkg::CMD_UINT) begin
      append_decimal(it.value[15:0]);
    end else begin
      mag = it.value;
      if (it.value[31]) begin
        append_char(dfmt_pkg::CH_MINUS);
        mag = ~it.value + 32'd1;
      end
      ipart = mag >> dfmt_pkg::FRAC_BITS;
      if (ipart > 32'hFFFF) begin
        ipart = 32'hFFFF;
      end
      append_decimal(ipart[15:0]);
      append_char(dfmt_pkg::CH_DOT);
      count = (it.ndig > dfmt_pkg::MAX_FRAC_DIGITS) ? dfmt_pkg::MAX_FRAC_DIGITS : it.ndig;
      frac = {32'd0, mag} & mask;
      for (int i = 0; i < count; i++) begin
        t = frac * 64'd10;
        append_char(dfmt_pkg::CH_ZERO + 8'(t >> dfmt_pkg::FRAC_BITS));
        frac = t & mask;
      end
    end
    expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  task automatic queue_item(input logic cmd, input logic [31:0] value, input logic [3:0] ndig);
    fmt_item_t it;
    it.cmd = cmd;
    it.value = value;
    it.ndig = ndig;
    pending_items.push_back(it);
  endtask

  // Random item: full-range values mixed with values of every magnitude.
  function automatic fmt_item_t random_item();
    fmt_item_t it;
    logic [31:0] mag;
    it.cmd = $urandom_range(1) ? dfmt_pkg::CMD_FIXED : dfmt_pkg::CMD_UINT;
    if ($urandom_range(2) == 0) begin
      it.value = $urandom;
    end else begin
      mag = $urandom >> $urandom_range(31);
      it.value = $urandom_range(1) ? -mag : mag;
    end
    if ($urandom_range(99) < 15) begin
      it.ndig = $urandom_range(15, 9);
    end else begin
      it.ndig = $urandom_range(8);
    end
    return it;
  endfunction

  // Sender: offers queued items and predicts the output of each accepted one.
  always @(posedge clk) begin : drive_items
    fmt_item_t nxt;
    fmt_item_t taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        taken.cmd = in_cmd;
        taken.value = in_value;
        taken.ndig = in_frac_digits;
        predict_chars(taken);
        items_taken++;
        if (in_cmd == dfmt_pkg::CMD_FIXED) begin
          fixed_taken++;
        end
      end
      if (pending_items.size() > 0 && !take_break()) begin
        nxt = pending_items.pop_front();
        in_cmd <= nxt.cmd;
        in_value <= nxt.value;
        in_frac_digits <= nxt.ndig;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the pipeline backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && chars_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 120;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
    end
  end

  // Monitor: every accepted character is checked against the oldest expectation.
  always @(posedge clk) begin : check_chars
    fmt_char_t want;
    if (rst_n && out_valid && out_ready) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char_code %h last %b with nothing expected",
                 $time, out_char_code, out_last);
        err_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char_code !== want.code) begin
          $display("%0t: char_code expected %h actual %h", $time, want.code, out_char_code);
          err_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    // Directed items: field extremes, sign handling, dot and digit clamping.
    queue_item(dfmt_pkg::CMD_UINT, 32'h0000_0000, 4'd0);
    queue_item(dfmt_pkg::CMD_UINT, 32'h0000_FFFF, 4'd0);
    queue_item(dfmt_pkg::CMD_UINT, 32'hFFFF_0007, 4'd15);
    queue_item(dfmt_pkg::CMD_UINT, 32'd9, 4'd3);
    queue_item(dfmt_pkg::CMD_UINT, 32'd10, 4'd0);
    queue_item(dfmt_pkg::CMD_UINT, 32'd100, 4'd0);
    queue_item(dfmt_pkg::CMD_UINT, 32'd1000, 4'd0);
    queue_item(dfmt_pkg::CMD_UINT, 32'd10000, 4'd0);
    queue_item(dfmt_pkg::CMD_UINT, 32'd9999, 4'd8);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h0000_0000, 4'd0);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h0001_0000, 4'd0);
    queue_item(dfmt_pkg::CMD_FIXED, 32'hFFFF_FFFF, 4'd8);
    queue_item(dfmt_pkg::CMD_FIXED, 32'hFFFF_FFFF, 4'd0);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h7FFF_FFFF, 4'd8);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h8000_0000, 4'd8);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h8000_0000, 4'd15);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h0001_8000, 4'd9);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h0001_8000, 4'd1);
    queue_item(dfmt_pkg::CMD_FIXED, 32'hFFFD_C000, 4'd3);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h0000_FFFF, 4'd8);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h0000_0001, 4'd15);
    queue_item(dfmt_pkg::CMD_FIXED, 32'h270F_1999, 4'd4);
    for (int i = 0; i < 148; i++) begin
      pending_items.push_back(random_item());
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every character to come out.
    do begin
      @(negedge clk);
    end while (pending_items.size() > 0 || in_valid || expected_chars.size() > 0);
    repeat (20) @(posedge clk);

    $display("Formatted %0d numbers (%0d fixed-point, %0d unsigned) into %0d characters,",
             items_taken, fixed_taken, items_taken - fixed_taken, chars_seen);
    $display("with random stalls on both sides and one long output hold-off.");
    if (err_count == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Run timed out with %0d characters still expected.", expected_chars.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
design/dfmt_pkg.sv
design/dfmt_emit.sv
design/decimal_number_formatter.sv
tb/testbench.sv
